FILE: src/hlso_pkg.sv
package hlso_pkg;

    localparam int LOCK_ID_W = 64;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic OP_LOCK = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    typedef struct packed {
        logic                 operation;
        logic [LOCK_ID_W-1:0] lock_id;
    } evt_word_t;

    typedef struct packed {
        logic [LOCK_ID_W-1:0] held_lock;
        logic [LOCK_ID_W-1:0] new_lock;
        logic                 last;
    } edge_word_t;

    // Per-cycle command shared by every stack cell
    typedef struct packed {
        logic rotate;
        logic close;
        logic load;
    } cell_ctrl_t;

endpackage

FILE: src/held_lock_stack_order_edges.sv
// Held-lock stack with lock-order edge output for one thread.
// Input channel evt_valid / evt_stall / evt_word carries lock and unlock
// words. Output channel edge_valid / edge_stall / edge_word carries, for a
// lock word, one order edge (held lock, new lock, last) per differing held entry.
// cfg_write / cfg_data set the enable bit; write it only while idle.
// Each accepted event passes through an accept step in ST_IDLE, a scan in
// ST_SCAN in which the ring of stack cells rotates once past the compare at
// its bottom cell, and a final step in ST_FIN that pushes the new lock or
// closes the gap left by an unlock. evt_stall stays high through the scan
// and the final step. Each edge waits until the next differing entry passes
// the bottom cell, or the final step for the last edge, and is offered
// on the cycle after that.
// A stalled receiver freezes the rotation until the output slot frees up.
// Reset empties the stack and clears enable; disabled or zero-id events
// are accepted and dropped without leaving the idle state.
module held_lock_stack_order_edges
    import hlso_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_data,
    input  logic       evt_valid,
    output logic       evt_stall,
    input  evt_word_t  evt_word,
    output logic       edge_valid,
    input  logic       edge_stall,
    output edge_word_t edge_word
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 enable_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [IDX_W-1:0]     step_reg;
    logic [IDX_W-1:0]     step_next;
    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     match_reg;
    logic [IDX_W-1:0]     match_next;
    logic                 op_reg;
    logic                 op_next;
    logic [LOCK_ID_W-1:0] id_reg;
    logic [LOCK_ID_W-1:0] id_next;

    logic [LOCK_ID_W-1:0] slot_data [STACK_DEPTH];
    cell_ctrl_t           ctrl;
    logic                 accept;
    logic                 ready;
    logic                 scan_go;
    logic                 fin_go;
    logic                 in_range;
    logic                 head_match;
    logic                 last_step;
    logic                 push;
    logic                 done;

    assign evt_stall = (state_reg != ST_IDLE);
    assign accept = evt_valid && !evt_stall;

    assign scan_go = (state_reg == ST_SCAN) && ready;
    assign fin_go = (state_reg == ST_FIN) && ready;
    assign in_range = CNT_W'(step_reg) < count_reg;
    assign head_match = (slot_data[0] == id_reg);
    assign last_step = (step_reg == IDX_W'(STACK_DEPTH - 1));
    assign push = scan_go && (op_reg == OP_LOCK) && in_range && !head_match;
    assign done = fin_go && (op_reg == OP_LOCK);

    assign ctrl.rotate = scan_go;
    assign ctrl.load = fin_go && (op_reg == OP_LOCK);
    assign ctrl.close = fin_go && (op_reg == OP_UNLOCK) && found_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next = step_reg;
        found_next = found_reg;
        match_next = match_reg;
        op_next = op_reg;
        id_next = id_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && enable_reg && (evt_word.lock_id != '0))
                begin
                    op_next = evt_word.operation;
                    id_next = evt_word.lock_id;
                    step_next = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    // the last match seen is the topmost one
                    if ((op_reg == OP_UNLOCK) && in_range && head_match)
                    begin
                        found_next = 1'b1;
                        match_next = step_reg;
                    end
                    if (last_step)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    if (op_reg == OP_LOCK)
                    begin
                        if (count_reg < CNT_W'(STACK_DEPTH))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (found_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            enable_reg <= 1'b0;
            count_reg <= '0;
            step_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg <= step_next;
            found_reg <= found_next;
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        op_reg <= op_next;
        id_reg <= id_next;
    end

    // Ring of cells: each takes from the one above, the top takes from the bottom
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        hlso_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .close_pos (match_reg),
            .load_pos  (count_reg),
            .load_id   (id_reg),
            .nbr       (slot_data[(i + 1) % STACK_DEPTH]),
            .slot      (slot_data[i])
        );
    end

    hlso_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .done       (done),
        .cand_held  (slot_data[0]),
        .cand_new   (id_reg),
        .ready      (ready),
        .edge_valid (edge_valid),
        .edge_stall (edge_stall),
        .edge_word  (edge_word)
    );

endmodule

FILE: src/hlso_cell.sv
module hlso_cell
    import hlso_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
)
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]     close_pos,
    input  logic [CNT_W-1:0]     load_pos,
    input  logic [LOCK_ID_W-1:0] load_id,
    input  logic [LOCK_ID_W-1:0] nbr,
    output logic [LOCK_ID_W-1:0] slot
);

    logic [LOCK_ID_W-1:0] slot_reg;
    logic [LOCK_ID_W-1:0] slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.load && (load_pos == CNT_W'(IDX)))
        begin
            slot_next = load_id;
        end
        else if (ctrl.rotate || (ctrl.close && (int'(close_pos) <= IDX)))
        begin
            // take the entry from the cell above
            slot_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

FILE: src/hlso_emit.sv
module hlso_emit
    import hlso_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 done,
    input  logic [LOCK_ID_W-1:0] cand_held,
    input  logic [LOCK_ID_W-1:0] cand_new,
    output logic                 ready,
    output logic                 edge_valid,
    input  logic                 edge_stall,
    output edge_word_t           edge_word
);

    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [LOCK_ID_W-1:0] pend_held_reg;
    logic [LOCK_ID_W-1:0] pend_held_next;
    logic [LOCK_ID_W-1:0] pend_new_reg;
    logic [LOCK_ID_W-1:0] pend_new_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    edge_word_t           out_word_reg;
    edge_word_t           out_word_next;
    logic                 load_out;

    // Output slot is free this cycle
    assign ready = !out_valid_reg || !edge_stall;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_held_next = pend_held_reg;
        pend_new_next = pend_new_reg;
        out_word_next = out_word_reg;
        load_out = 1'b0;
        if (ready && push)
        begin
            // hold the newest edge back until we know whether it is the last
            if (pend_valid_reg)
            begin
                load_out = 1'b1;
                out_word_next.held_lock = pend_held_reg;
                out_word_next.new_lock = pend_new_reg;
                out_word_next.last = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_held_next = cand_held;
            pend_new_next = cand_new;
        end
        else if (ready && done && pend_valid_reg)
        begin
            load_out = 1'b1;
            out_word_next.held_lock = pend_held_reg;
            out_word_next.new_lock = pend_new_reg;
            out_word_next.last = 1'b1;
            pend_valid_next = 1'b0;
        end
        out_valid_next = (out_valid_reg && edge_stall) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_held_reg <= pend_held_next;
        pend_new_reg <= pend_new_next;
        out_word_reg <= out_word_next;
    end

    assign edge_valid = out_valid_reg;
    assign edge_word = out_word_reg;

endmodule

FILE: tb/held_lock_stack_order_edges_tb.sv
`timescale 1ns / 100ps

module held_lock_stack_order_edges_tb;
    import hlso_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_data = 1'b0;
    logic       evt_valid = 1'b0;
    logic       evt_stall;
    evt_word_t  evt_word = '0;
    logic       edge_valid;
    logic       edge_stall = 1'b0;
    edge_word_t edge_word;

    // Stimulus and scoreboard state
    evt_word_t             pending_events[$];
    edge_word_t            expected_edges[$];
    logic [LOCK_ID_W-1:0]  issued_ids[$];
    logic [LOCK_ID_W-1:0]  held_ids[STACK_DEPTH_DEF];
    int                    held_depth = 0;
    logic                  tracking_on = 1'b0;
    int                    mismatches = 0;

    // Sender and receiver knobs
    int          gap_max = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    logic [15:0] stall_bits = 16'h0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;

    held_lock_stack_order_edges DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_word   (evt_word),
        .edge_valid (edge_valid),
        .edge_stall (edge_stall),
        .edge_word  (edge_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the held-lock stack for one accepted word and queue its order edges
    function automatic void predict_edges(input evt_word_t w);
        edge_word_t batch[$];
        edge_word_t e;
        if (!tracking_on || w.lock_id == '0)
            return;
        if (w.operation == OP_LOCK)
        begin
            for (int i = 0; i < held_depth; i++)
            begin
                if (held_ids[i] != w.lock_id)
                begin
                    e.held_lock = held_ids[i];
                    e.new_lock = w.lock_id;
                    e.last = 1'b0;
                    batch.push_back(e);
                end
            end
            if (batch.size() != 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j])
                expected_edges.push_back(batch[j]);
            // full stack: drop the push
            if (held_depth < STACK_DEPTH_DEF)
            begin
                held_ids[held_depth] = w.lock_id;
                held_depth++;
            end
        end
        else
        begin
            for (int i = held_depth - 1; i >= 0; i--)
            begin
                if (held_ids[i] == w.lock_id)
                begin
                    for (int k = i; k + 1 < held_depth; k++)
                        held_ids[k] = held_ids[k + 1];
                    held_depth--;
                    break;
                end
            end
        end
    endfunction

    function automatic logic [LOCK_ID_W-1:0] pick_lock_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 40)
            return LOCK_ID_W'($urandom_range(1, 8));
        if (roll < 52 && issued_ids.size() != 0)
            return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    // Queue one enabled word and track what the thread should hold
    task automatic queue_event(input logic op, input logic [LOCK_ID_W-1:0] id);
        evt_word_t w;
        w.operation = op;
        w.lock_id = id;
        pending_events.push_back(w);
        if (id == '0)
            return;
        if (op == OP_LOCK)
        begin
            if (issued_ids.size() < STACK_DEPTH_DEF)
                issued_ids.push_back(id);
        end
        else
        begin
            for (int i = issued_ids.size() - 1; i >= 0; i--)
            begin
                if (issued_ids[i] == id)
                begin
                    issued_ids.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic queue_random(input int n_items, input int lock_pct);
        for (int k = 0; k < n_items; k++)
        begin
            if (issued_ids.size() == 0 || $urandom_range(0, 99) < lock_pct)
                queue_event(OP_LOCK, pick_lock_id());
            else if ($urandom_range(0, 99) < 85)
                queue_event(OP_UNLOCK, issued_ids[$urandom_range(0, issued_ids.size() - 1)]);
            else
                queue_event(OP_UNLOCK, pick_lock_id());
        end
    endtask

    // Wait for all words sent and all edges back, then let the block settle
    task automatic wait_idle();
        while (!(pending_events.size() == 0 && !evt_valid && expected_edges.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        tracking_on = value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Event driver: bursts with random gaps, hold the word while stalled
    always @(posedge clk)
    begin
        logic      nxt_valid;
        evt_word_t nxt_word;
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
        end
        else
        begin
            nxt_valid = evt_valid;
            nxt_word = evt_word;
            if (evt_valid && !evt_stall)
            begin
                predict_edges(evt_word);
                pending_events.delete(0);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
                if (gap_left > 0)
                    gap_left--;
                else if (pending_events.size() != 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_word = pending_events[0];
                    burst_left--;
                end
            end
            evt_valid <= nxt_valid;
            evt_word <= nxt_word;
        end
    end

    // Edge monitor and receiver stall
    always @(posedge clk)
    begin
        edge_word_t want;
        logic       nxt_stall;
        if (!rst_n)
        begin
            edge_stall <= 1'b0;
            stall_bits = $urandom_range(1, 16'hFFFE);
        end
        else
        begin
            if (edge_valid && !edge_stall)
            begin
                if (expected_edges.size() == 0)
                begin
                    $display("%0t: unexpected edge held=%h new=%h last=%b", $time,
                             edge_word.held_lock, edge_word.new_lock, edge_word.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (edge_word.held_lock !== want.held_lock ||
                        edge_word.new_lock !== want.new_lock ||
                        edge_word.last !== want.last)
                    begin
                        $display("%0t: edge mismatch: expected held=%h new=%h last=%b",
                                 $time, want.held_lock, want.new_lock, want.last);
                        $display("%0t:                got      held=%h new=%h last=%b",
                                 $time, edge_word.held_lock, edge_word.new_lock,
                                 edge_word.last);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                nxt_stall = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_RANDOM:  nxt_stall = ($urandom_range(0, 99) < 35);
                    STALL_PATTERN: nxt_stall = stall_bits[0];
                    default:       nxt_stall = 1'b0;
                endcase
            end
            stall_bits = {stall_bits[0], stall_bits[15:1]};
            edge_stall <= nxt_stall;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tracking off after reset: drop everything
        pending_events.push_back('{operation: OP_LOCK, lock_id: 64'h11});
        pending_events.push_back('{operation: OP_UNLOCK, lock_id: 64'h11});
        wait_idle();
        write_enable(1'b1);

        queue_event(OP_LOCK, '0);
        queue_event(OP_UNLOCK, '0);
        queue_event(OP_LOCK, 64'h1);
        queue_event(OP_LOCK, '1);
        queue_event(OP_LOCK, 64'h1);
        queue_event(OP_UNLOCK, 64'h77);
        queue_event(OP_UNLOCK, 64'h1);
        queue_event(OP_LOCK, 64'h5555_5555_5555_5555);
        queue_event(OP_LOCK, 64'hAAAA_AAAA_AAAA_AAAA);
        for (int i = 0; i < 12; i++)
            queue_event(OP_LOCK, 64'h100 + i);
        // stack full: edges still come, push dropped
        queue_event(OP_LOCK, 64'hDEAD);
        queue_event(OP_UNLOCK, '1);
        queue_event(OP_LOCK, '1);
        queue_random(110, 60);
        wait_idle();

        write_enable(1'b0);
        gap_max <= 4;
        stall_mode <= STALL_RANDOM;
        for (int i = 0; i < 40; i++)
            pending_events.push_back('{operation: logic'($urandom_range(0, 1)),
                                       lock_id: pick_lock_id()});
        wait_idle();
        write_enable(1'b1);

        // long receiver hold-off while words keep coming
        gap_max <= 6;
        hold_requests <= hold_requests + 1;
        queue_random(150, 55);
        wait_idle();

        gap_max <= 2;
        stall_mode <= STALL_PATTERN;
        queue_random(104, 70);
        wait_idle();

        if (mismatches == 0)
            $display("held_lock_stack_order_edges_tb OK");
        else
            $display("held_lock_stack_order_edges_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("held_lock_stack_order_edges_tb NOT OK");
        $finish;
    end

endmodule

FILE: held_lock_stack_order_edges.f
src/hlso_pkg.sv
src/hlso_cell.sv
src/hlso_emit.sv
src/held_lock_stack_order_edges.sv
tb/held_lock_stack_order_edges_tb.sv
